### sv/sbo_pkg.sv
// Shared widths, types and field helpers for the sphere/box overlap pipeline.
package sbo_pkg;

  // Field formats
  localparam int COORD_BITS = 16;
  localparam int AXIS_BITS  = 16;
  localparam int AXIS_FRAC  = 14;
  localparam int PACK_BITS  = 48;
  localparam int RAD_BITS   = 16;

  // Padded widths so that slices beyond the packed word read as zero
  localparam int PAD_W  = (3 * COORD_BITS > PACK_BITS) ? 3 * COORD_BITS : PACK_BITS;
  localparam int RPAD_W = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS;

  // Datapath widths
  localparam int D_W   = COORD_BITS + 1;             // center offset
  localparam int M_W   = D_W + AXIS_BITS;            // offset times axis component
  localparam int P_W   = M_W + 2;                    // projection, sum of three
  localparam int H_W   = COORD_BITS + AXIS_FRAC;     // half size at projection scale
  localparam int T_W   = H_W + 1;                    // clamped projection
  localparam int Q_W   = AXIS_BITS + T_W;            // axis component times clamp
  localparam int E_W   = Q_W + 2;                    // closest-point offset, sum of four
  localparam int ESH   = 2 * AXIS_FRAC;              // scale of the closest-point offset
  localparam int ER_W  = E_W - ESH;                  // rounded offset
  localparam int SQ_W  = 2 * ER_W + 2;               // box distance squared
  localparam int R_W   = COORD_BITS + 1;             // radius sum
  localparam int DS_W  = 2 * D_W + 2;                // sphere distance squared

  typedef enum logic {
    OP_SPHERE = 1'b0,
    OP_BOX    = 1'b1
  } op_t;

  typedef logic signed [D_W-1:0]       off_t;
  typedef logic signed [AXIS_BITS-1:0] axis_t;
  typedef logic signed [T_W-1:0]       clamp_t;
  typedef logic [COORD_BITS-1:0]       mag_t;

  // Item state handed from the projection half to the closest-point half
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  sphere_hit;
    off_t [2:0]            d;
    axis_t [2:0][2:0]      ax;     // [axis][component]
    clamp_t [2:0]          t;
    mag_t                  rb;
  } proj_t;

  // Signed coordinate k of a packed word, sign extended to offset width
  function automatic off_t coord_of(input logic [PACK_BITS-1:0] v, input int k);
    logic [PAD_W-1:0]      w;
    logic [COORD_BITS-1:0] s;
    w = PAD_W'(v);
    s = w[k*COORD_BITS +: COORD_BITS];
    return off_t'(signed'(s));
  endfunction

  // Unsigned magnitude k of a packed word
  function automatic mag_t mag_of(input logic [PACK_BITS-1:0] v, input int k);
    logic [PAD_W-1:0] w;
    w = PAD_W'(v);
    return w[k*COORD_BITS +: COORD_BITS];
  endfunction

  // Radius read as its low COORD_BITS bits
  function automatic mag_t radius_of(input logic [RAD_BITS-1:0] v);
    logic [RPAD_W-1:0] w;
    w = RPAD_W'(v);
    return w[COORD_BITS-1:0];
  endfunction

  // Signed Q2.14 axis component k
  function automatic axis_t axis_of(input logic [PACK_BITS-1:0] v, input int k);
    return signed'(v[k*AXIS_BITS +: AXIS_BITS]);
  endfunction

endpackage

### sv/sbo_project.sv
// Stages 1-3: center offset, projections on the box axes with clamping, sphere-sphere test.
module sbo_project (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_operation,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_center,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_0,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_1,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_2,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_half_sizes,
  input  logic [sbo_pkg::RAD_BITS-1:0]  in_a_radius,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_b_center,
  input  logic [sbo_pkg::RAD_BITS-1:0]  in_b_radius,
  output sbo_pkg::proj_t                proj
);

  // Stage 1 registers
  logic                  v1_r;
  sbo_pkg::op_t          op1_r;
  sbo_pkg::off_t         d1_r  [3];
  sbo_pkg::axis_t        ax1_r [3][3];
  sbo_pkg::mag_t         h1_r  [3];
  logic [sbo_pkg::R_W-1:0] rs1_r;
  sbo_pkg::mag_t         rb1_r;

  // Stage 2 registers
  logic                          v2_r;
  sbo_pkg::op_t                  op2_r;
  logic signed [sbo_pkg::M_W-1:0] pr2_r [3][3];  // [axis][component]
  logic [2*sbo_pkg::D_W-1:0]     dsq2_r [3];
  logic [2*sbo_pkg::R_W-1:0]     rsq2_r;
  sbo_pkg::off_t                 d2_r  [3];
  sbo_pkg::axis_t                ax2_r [3][3];
  sbo_pkg::mag_t                 h2_r  [3];
  sbo_pkg::mag_t                 rb2_r;

  // Stage 3 registers
  logic                  v3_r;
  sbo_pkg::op_t          op3_r;
  logic                  shit3_r;
  sbo_pkg::clamp_t       t3_r  [3];
  sbo_pkg::off_t         d3_r  [3];
  sbo_pkg::axis_t        ax3_r [3][3];
  sbo_pkg::mag_t         rb3_r;

  // Combinational next values
  sbo_pkg::off_t                   d1_nxt  [3];
  sbo_pkg::axis_t                  ax1_nxt [3][3];
  sbo_pkg::mag_t                   h1_nxt  [3];
  logic [sbo_pkg::R_W-1:0]         rs1_nxt;
  logic signed [sbo_pkg::M_W-1:0]  pr2_nxt [3][3];
  logic [2*sbo_pkg::D_W-1:0]       dsq2_nxt [3];
  logic [2*sbo_pkg::R_W-1:0]       rsq2_nxt;
  sbo_pkg::clamp_t                 t3_nxt [3];
  logic                            shit3_nxt;

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: unpack fields and form the center offset
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d1_nxt[c] = sbo_pkg::coord_of(in_b_center, c) - sbo_pkg::coord_of(in_a_center, c);
      h1_nxt[c] = sbo_pkg::mag_of(in_a_half_sizes, c);
      ax1_nxt[0][c] = sbo_pkg::axis_of(in_a_axis_0, c);
      ax1_nxt[1][c] = sbo_pkg::axis_of(in_a_axis_1, c);
      ax1_nxt[2][c] = sbo_pkg::axis_of(in_a_axis_2, c);
    end
    rs1_nxt = sbo_pkg::R_W'(sbo_pkg::radius_of(in_a_radius))
            + sbo_pkg::R_W'(sbo_pkg::radius_of(in_b_radius));
  end

  always_ff @(posedge clk) begin
    op1_r <= sbo_pkg::op_t'(in_operation);
    d1_r  <= d1_nxt;
    ax1_r <= ax1_nxt;
    h1_r  <= h1_nxt;
    rs1_r <= rs1_nxt;
    rb1_r <= sbo_pkg::radius_of(in_b_radius);
  end

  // Stage 2: one product per axis and component, plus the sphere squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        pr2_nxt[i][c] = sbo_pkg::M_W'(d1_r[c]) * sbo_pkg::M_W'(ax1_r[i][c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      dsq2_nxt[c] = unsigned'((2*sbo_pkg::D_W)'(d1_r[c]) * (2*sbo_pkg::D_W)'(d1_r[c]));
    end
    rsq2_nxt = (2*sbo_pkg::R_W)'(rs1_r) * (2*sbo_pkg::R_W)'(rs1_r);
  end

  always_ff @(posedge clk) begin
    op2_r  <= op1_r;
    pr2_r  <= pr2_nxt;
    dsq2_r <= dsq2_nxt;
    rsq2_r <= rsq2_nxt;
    d2_r   <= d1_r;
    ax2_r  <= ax1_r;
    h2_r   <= h1_r;
    rb2_r  <= rb1_r;
  end

  // Stage 3: sum projections, clamp to the half sizes, finish the sphere test
  always_comb begin
    logic signed [sbo_pkg::P_W-1:0] p;
    logic signed [sbo_pkg::P_W-1:0] hp;
    logic signed [sbo_pkg::P_W-1:0] hn;
    logic [sbo_pkg::DS_W-1:0]       ds;
    for (int i = 0; i < 3; i++) begin
      p  = sbo_pkg::P_W'(pr2_r[i][0]) + sbo_pkg::P_W'(pr2_r[i][1])
         + sbo_pkg::P_W'(pr2_r[i][2]);
      hp = signed'(sbo_pkg::P_W'({h2_r[i], {sbo_pkg::AXIS_FRAC{1'b0}}}));
      hn = -hp;
      if (p > hp) begin
        t3_nxt[i] = sbo_pkg::T_W'(hp);
      end else if (p < hn) begin
        t3_nxt[i] = sbo_pkg::T_W'(hn);
      end else begin
        t3_nxt[i] = sbo_pkg::T_W'(p);
      end
    end
    ds = sbo_pkg::DS_W'(dsq2_r[0]) + sbo_pkg::DS_W'(dsq2_r[1]) + sbo_pkg::DS_W'(dsq2_r[2]);
    shit3_nxt = ds < sbo_pkg::DS_W'(rsq2_r);
  end

  always_ff @(posedge clk) begin
    op3_r   <= op2_r;
    shit3_r <= shit3_nxt;
    t3_r    <= t3_nxt;
    d3_r    <= d2_r;
    ax3_r   <= ax2_r;
    rb3_r   <= rb2_r;
  end

  // Hand the item on
  always_comb begin
    proj.valid      = v3_r;
    proj.op         = op3_r;
    proj.sphere_hit = shit3_r;
    proj.rb         = rb3_r;
    for (int i = 0; i < 3; i++) begin
      proj.d[i] = d3_r[i];
      proj.t[i] = t3_r[i];
      for (int c = 0; c < 3; c++) begin
        proj.ax[i][c] = ax3_r[i][c];
      end
    end
  end

endmodule

### sv/sbo_closest.sv
// Stages 4-7: closest point on the box, rounding, squared distance and the final hit.
module sbo_closest (
  input  logic           clk,
  input  logic           rst_n,
  input  sbo_pkg::proj_t proj,
  output logic           out_valid,
  output logic           out_hit
);

  localparam logic signed [sbo_pkg::E_W-1:0] RND_HALF =
    sbo_pkg::E_W'(1) <<< (sbo_pkg::ESH - 1);

  // Stage 4 registers
  logic                           v4_r;
  sbo_pkg::op_t                   op4_r;
  logic                           shit4_r;
  logic signed [sbo_pkg::Q_W-1:0] q4_r  [3][3];   // [component][axis]
  logic signed [sbo_pkg::E_W-1:0] dn4_r [3];
  logic [2*sbo_pkg::COORD_BITS-1:0] rsq4_r;

  // Stage 5 registers
  logic                            v5_r;
  sbo_pkg::op_t                    op5_r;
  logic                            shit5_r;
  logic signed [sbo_pkg::ER_W-1:0] er5_r [3];
  logic [2*sbo_pkg::COORD_BITS-1:0] rsq5_r;

  // Stage 6 registers
  logic                            v6_r;
  sbo_pkg::op_t                    op6_r;
  logic                            shit6_r;
  logic [2*sbo_pkg::ER_W-1:0]      sq6_r [3];
  logic [2*sbo_pkg::COORD_BITS-1:0] rsq6_r;

  // Stage 7 registers
  logic v7_r;
  logic hit7_r;

  logic signed [sbo_pkg::Q_W-1:0]  q4_nxt  [3][3];
  logic signed [sbo_pkg::E_W-1:0]  dn4_nxt [3];
  logic signed [sbo_pkg::ER_W-1:0] er5_nxt [3];
  logic [2*sbo_pkg::ER_W-1:0]      sq6_nxt [3];
  logic                            hit7_nxt;

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v4_r <= proj.valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Stage 4: axis components times clamped projections, negated offset at full scale
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        q4_nxt[c][i] = sbo_pkg::Q_W'(proj.ax[i][c]) * sbo_pkg::Q_W'(proj.t[i]);
      end
      dn4_nxt[c] = -(sbo_pkg::E_W'(proj.d[c]) <<< sbo_pkg::ESH);
    end
  end

  always_ff @(posedge clk) begin
    op4_r   <= proj.op;
    shit4_r <= proj.sphere_hit;
    q4_r    <= q4_nxt;
    dn4_r   <= dn4_nxt;
    rsq4_r  <= (2*sbo_pkg::COORD_BITS)'(proj.rb) * (2*sbo_pkg::COORD_BITS)'(proj.rb);
  end

  // Stage 5: sum the closest-point offset and round to nearest, ties up
  always_comb begin
    logic signed [sbo_pkg::E_W-1:0] e;
    for (int c = 0; c < 3; c++) begin
      e = dn4_r[c] + sbo_pkg::E_W'(q4_r[c][0]) + sbo_pkg::E_W'(q4_r[c][1])
        + sbo_pkg::E_W'(q4_r[c][2]);
      er5_nxt[c] = sbo_pkg::ER_W'((e + RND_HALF) >>> sbo_pkg::ESH);
    end
  end

  always_ff @(posedge clk) begin
    op5_r   <= op4_r;
    shit5_r <= shit4_r;
    er5_r   <= er5_nxt;
    rsq5_r  <= rsq4_r;
  end

  // Stage 6: square each rounded component
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq6_nxt[c] = unsigned'((2*sbo_pkg::ER_W)'(er5_r[c]) * (2*sbo_pkg::ER_W)'(er5_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    op6_r   <= op5_r;
    shit6_r <= shit5_r;
    sq6_r   <= sq6_nxt;
    rsq6_r  <= rsq5_r;
  end

  // Stage 7: compare against the squared radius and pick the result by operation
  always_comb begin
    logic [sbo_pkg::SQ_W-1:0] dist2;
    dist2 = sbo_pkg::SQ_W'(sq6_r[0]) + sbo_pkg::SQ_W'(sq6_r[1]) + sbo_pkg::SQ_W'(sq6_r[2]);
    case (op6_r)
      sbo_pkg::OP_SPHERE: hit7_nxt = shit6_r;
      sbo_pkg::OP_BOX:    hit7_nxt = dist2 <= sbo_pkg::SQ_W'(rsq6_r);
      default:            hit7_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    hit7_r <= hit7_nxt;
  end

  assign out_valid = v7_r;
  assign out_hit   = hit7_r;

endmodule

### sv/sphere_box_overlap_test.sv
// Pair-overlap query unit: sphere against sphere or oriented box against sphere.
//
// Usage:
//   Raise start with one query on the in_ ports; the item is taken at the rising
//   edge where start is high and busy is low. in_operation selects the test:
//   sphere-sphere (strict, touching is a miss) or box-sphere (touching is a hit).
//   Each item gives exactly one result: out_valid is high for one cycle with
//   out_hit, and the receiver takes it in that cycle.
// Latency and throughput:
//   Seven register stages lie between an item being taken and its result at the
//   ports. One item can be taken every cycle; the pipeline depth, set by the
//   multiplier stages for the projections, the closest point and the squares,
//   fixes the latency and not the rate.
// Reset:
//   rst_n is synchronous, active low. It clears all valid bits, so items in
//   flight are dropped. busy is high during reset, falls at the first edge that
//   samples rst_n high, and is low from then on.
// Stalls:
//   The receiver cannot stall; the pipeline advances every cycle.
module sphere_box_overlap_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_center,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_0,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_1,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_axis_2,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_a_half_sizes,
  input  logic [sbo_pkg::RAD_BITS-1:0]  in_a_radius,
  input  logic [sbo_pkg::PACK_BITS-1:0] in_b_center,
  input  logic [sbo_pkg::RAD_BITS-1:0]  in_b_radius,
  output logic                          out_valid,
  output logic                          out_hit
);

  logic           busy_r;
  logic           in_acc;
  sbo_pkg::proj_t proj;

  // Hold busy through reset, until the first edge that samples rst_n high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  sbo_project u_project (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_acc),
    .in_operation    (in_operation),
    .in_a_center     (in_a_center),
    .in_a_axis_0     (in_a_axis_0),
    .in_a_axis_1     (in_a_axis_1),
    .in_a_axis_2     (in_a_axis_2),
    .in_a_half_sizes (in_a_half_sizes),
    .in_a_radius     (in_a_radius),
    .in_b_center     (in_b_center),
    .in_b_radius     (in_b_radius),
    .proj            (proj)
  );

  sbo_closest u_closest (
    .clk       (clk),
    .rst_n     (rst_n),
    .proj      (proj),
    .out_valid (out_valid),
    .out_hit   (out_hit)
  );

  // Every result comes from an item taken at the input
  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 7))
    else $error("result without a matching item");

  // Every item taken yields a result
  a_item_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##7 out_valid)
    else $error("item lost in the pipeline");

  // Mid-pipeline valid comes from an item taken at the input
  a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
    proj.valid |-> $past(in_acc, 3))
    else $error("stage three valid out of step");

  // Busy only around reset
  a_busy_reset: assert property (@(posedge clk)
    (rst_n && $past(rst_n)) |-> !busy)
    else $error("busy outside reset");

endmodule

### sim/testbench.sv
// Self-checking testbench for the sphere/box overlap query pipeline.
module testbench;

  localparam int RANDOM_QUERIES = 450;
  localparam int IDLE_LIMIT     = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;

  typedef logic [sbo_pkg::PACK_BITS-1:0] pack_t;
  typedef logic [sbo_pkg::RAD_BITS-1:0]  rad_t;

  localparam logic [sbo_pkg::AXIS_BITS-1:0] AXIS_ONE = 16'h4000;
  localparam pack_t UNIT_X = {16'h0000, 16'h0000, AXIS_ONE};
  localparam pack_t UNIT_Y = {16'h0000, AXIS_ONE, 16'h0000};
  localparam pack_t UNIT_Z = {AXIS_ONE, 16'h0000, 16'h0000};
  localparam pack_t ALL_ONES = {sbo_pkg::PACK_BITS{1'b1}};

  // One overlap query plus its sender-side timing
  typedef struct {
    sbo_pkg::op_t op;
    pack_t a_center;
    pack_t axis [3];
    pack_t half;
    rad_t  a_radius;
    pack_t b_center;
    rad_t  b_radius;
    int    gap;
    bit    drain;
  } query_t;

  logic  clk;
  logic  rst_n           = 1'b0;
  logic  start           = 1'b0;
  logic  busy;
  logic  in_operation    = 1'b0;
  pack_t in_a_center     = '0;
  pack_t in_a_axis_0     = '0;
  pack_t in_a_axis_1     = '0;
  pack_t in_a_axis_2     = '0;
  pack_t in_a_half_sizes = '0;
  rad_t  in_a_radius     = '0;
  pack_t in_b_center     = '0;
  rad_t  in_b_radius     = '0;
  logic  out_valid;
  logic  out_hit;

  query_t query_q [$];
  logic   hit_expect_q [$];
  int     fail_cnt   = 0;
  int     result_cnt = 0;
  bit     burst      = 1'b0;
  bit     drain_next = 1'b0;

  sphere_box_overlap_test dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_a_center     (in_a_center),
    .in_a_axis_0     (in_a_axis_0),
    .in_a_axis_1     (in_a_axis_1),
    .in_a_axis_2     (in_a_axis_2),
    .in_a_half_sizes (in_a_half_sizes),
    .in_a_radius     (in_a_radius),
    .in_b_center     (in_b_center),
    .in_b_radius     (in_b_radius),
    .out_valid       (out_valid),
    .out_hit         (out_hit)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Signed Q12.4 coordinate k of a packed word
  function automatic longint coord_at(pack_t v, int k);
    logic signed [sbo_pkg::COORD_BITS-1:0] s;
    s = v[k*sbo_pkg::COORD_BITS +: sbo_pkg::COORD_BITS];
    return s;
  endfunction

  // Signed Q2.14 axis component k of a packed word
  function automatic longint comp_at(pack_t v, int k);
    logic signed [sbo_pkg::AXIS_BITS-1:0] s;
    s = v[k*sbo_pkg::AXIS_BITS +: sbo_pkg::AXIS_BITS];
    return s;
  endfunction

  // Overlap verdict of one query, exact integer arithmetic
  function automatic logic overlap_of(query_t q);
    longint d [3];
    longint ax [3][3];
    longint t [3];
    longint rb, rsum, h, p, e, er, dist2;
    int     c, i;
    rb    = longint'(q.b_radius[sbo_pkg::COORD_BITS-1:0]);
    dist2 = 0;
    for (c = 0; c < 3; c++) d[c] = coord_at(q.b_center, c) - coord_at(q.a_center, c);
    if (q.op == sbo_pkg::OP_SPHERE) begin
      rsum = longint'(q.a_radius[sbo_pkg::COORD_BITS-1:0]) + rb;
      for (c = 0; c < 3; c++) dist2 += d[c] * d[c];
      return dist2 < rsum * rsum;
    end
    // project the offset on each axis and clamp to the half size
    for (i = 0; i < 3; i++) begin
      h = longint'(q.half[i*sbo_pkg::COORD_BITS +: sbo_pkg::COORD_BITS])
        * (longint'(1) <<< sbo_pkg::AXIS_FRAC);
      p = 0;
      for (c = 0; c < 3; c++) begin
        ax[i][c] = comp_at(q.axis[i], c);
        p += d[c] * ax[i][c];
      end
      if (p > h) p = h;
      if (p < -h) p = -h;
      t[i] = p;
    end
    // closest point minus sphere center, rounded half up to coordinate scale
    for (c = 0; c < 3; c++) begin
      e = -d[c] * (longint'(1) <<< (2 * sbo_pkg::AXIS_FRAC));
      for (i = 0; i < 3; i++) e += ax[i][c] * t[i];
      er = (e + (longint'(1) <<< (2 * sbo_pkg::AXIS_FRAC - 1))) >>> (2 * sbo_pkg::AXIS_FRAC);
      dist2 += er * er;
    end
    return dist2 <= rb * rb;
  endfunction

  function automatic pack_t pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  // Negate each 16-bit component of a packed axis
  function automatic pack_t neg3(pack_t v);
    return {16'(-v[47:32]), 16'(-v[31:16]), 16'(-v[15:0])};
  endfunction

  function automatic pack_t rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Signed value spread evenly over +-span
  function automatic logic [15:0] near(int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic push_query(sbo_pkg::op_t op, pack_t ac, pack_t ax0, pack_t ax1,
                            pack_t ax2, pack_t half, rad_t ar, pack_t bc, rad_t br);
    query_t q;
    q.op       = op;
    q.a_center = ac;
    q.axis[0]  = ax0;
    q.axis[1]  = ax1;
    q.axis[2]  = ax2;
    q.half     = half;
    q.a_radius = ar;
    q.b_center = bc;
    q.b_radius = br;
    q.gap      = burst ? 0 : $urandom_range(0, 8);
    q.drain    = drain_next;
    drain_next = 1'b0;
    query_q    = {query_q, q};
  endtask

  // Present queued items, each after its gap (and, if marked drain, once all results are in); hold each until taken
  always @(posedge clk) begin
    query_t nxt;
    logic   go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        hit_expect_q = {hit_expect_q, overlap_of(nxt)};
        go = 1'b0;
      end
      if (!go && query_q.size() != 0) begin
        if (query_q[0].gap != 0) begin
          query_q[0].gap = query_q[0].gap - 1;
        end else if (!query_q[0].drain || hit_expect_q.size() == 0) begin
          nxt = query_q.pop_front();
          go  = 1'b1;
          in_operation    <= nxt.op;
          in_a_center     <= nxt.a_center;
          in_a_axis_0     <= nxt.axis[0];
          in_a_axis_1     <= nxt.axis[1];
          in_a_axis_2     <= nxt.axis[2];
          in_a_half_sizes <= nxt.half;
          in_a_radius     <= nxt.a_radius;
          in_b_center     <= nxt.b_center;
          in_b_radius     <= nxt.b_radius;
        end
      end
      start <= go;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid) begin
      result_cnt++;
      if (hit_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("result %0d: unexpected item, hit=%b", result_cnt, out_hit);
      end else begin
        want = hit_expect_q.pop_front();
        if (out_hit !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("result %0d: hit expected %b, got %b", result_cnt, want, out_hit);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    query_t q;
    int     n, kind, span, c, len, lim;
    pack_t  axes [3];
    pack_t  units [3];
    logic [15:0] ctr [3];
    logic [15:0] hs [3];
    rad_t   ra, rb;

    units[0] = UNIT_X;
    units[1] = UNIT_Y;
    units[2] = UNIT_Z;

    // sphere pairs: empty, touching, just overlapping, extremes
    push_query(sbo_pkg::OP_SPHERE, '0, '0, '0, '0, '0, '0, '0, '0);
    push_query(sbo_pkg::OP_SPHERE, '0, '0, '0, '0, '0, 16'd16, pack3(16'd32, 0, 0), 16'd16);
    push_query(sbo_pkg::OP_SPHERE, '0, '0, '0, '0, '0, 16'd16, pack3(16'd32, 0, 0), 16'd17);
    push_query(sbo_pkg::OP_SPHERE, pack3(16'h8000, 16'h8000, 16'h8000), ALL_ONES, ALL_ONES,
               ALL_ONES, ALL_ONES, 16'hFFFF, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF);
    push_query(sbo_pkg::OP_SPHERE, ALL_ONES, '0, '0, '0, '0, '0, ALL_ONES, '0);
    push_query(sbo_pkg::OP_SPHERE, '0, '0, '0, '0, '0, 16'd2, pack3(16'd1, 0, 0), '0);
    push_query(sbo_pkg::OP_SPHERE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 16'hFFFF,
               ALL_ONES, 16'hFFFF);

    // box against sphere: touching face, just apart, inside, zero axes
    push_query(sbo_pkg::OP_BOX, '0, UNIT_X, UNIT_Y, UNIT_Z, pack3(16'd16, 16'd16, 16'd16),
               16'hFFFF, pack3(16'd32, 0, 0), 16'd16);
    push_query(sbo_pkg::OP_BOX, '0, UNIT_X, UNIT_Y, UNIT_Z, pack3(16'd16, 16'd16, 16'd16), '0,
               pack3(16'd32, 0, 0), 16'd15);
    push_query(sbo_pkg::OP_BOX, '0, UNIT_X, UNIT_Y, UNIT_Z, pack3(16'd16, 16'd16, 16'd16), '0,
               pack3(16'd5, 16'hFFF9, 16'd3), '0);
    push_query(sbo_pkg::OP_BOX, '0, '0, '0, '0, ALL_ONES, '0, pack3(16'd16, 0, 0), 16'd16);
    push_query(sbo_pkg::OP_BOX, '0, '0, '0, '0, ALL_ONES, '0, pack3(16'd16, 0, 0), 16'd15);
    push_query(sbo_pkg::OP_BOX, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
               ALL_ONES, 16'hFFFF);
    push_query(sbo_pkg::OP_BOX, pack3(16'h8000, 16'h8000, 16'h8000), {3{16'h8000}},
               {3{16'h8000}}, {3{16'h8000}}, ALL_ONES, '0,
               pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF);
    push_query(sbo_pkg::OP_BOX, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), {3{16'h7FFF}},
               {3{16'h7FFF}}, {3{16'h7FFF}}, ALL_ONES, '0,
               pack3(16'h8000, 16'h8000, 16'h8000), '0);

    // rotated box, mirrored axes near a corner, point box, shifted center
    push_query(sbo_pkg::OP_BOX, '0, pack3(16'h2D41, 16'h2D41, 0), pack3(16'hD2BF, 16'h2D41, 0),
               UNIT_Z, pack3(16'd16, 16'd16, 16'd16), '0, pack3(16'd40, 0, 0), 16'd16);
    push_query(sbo_pkg::OP_BOX, '0, pack3(16'hC000, 0, 0), pack3(0, 16'hC000, 0), UNIT_Z,
               pack3(16'd16, 16'd16, 16'd16), '0, pack3(16'd32, 16'd32, 0), 16'd23);
    push_query(sbo_pkg::OP_BOX, '0, pack3(16'hC000, 0, 0), pack3(0, 16'hC000, 0), UNIT_Z,
               pack3(16'd16, 16'd16, 16'd16), '0, pack3(16'd32, 16'd32, 0), 16'd22);
    push_query(sbo_pkg::OP_BOX, '0, UNIT_X, UNIT_Y, UNIT_Z, '0, '0, pack3(16'd3, 16'd4, 0),
               16'd5);
    push_query(sbo_pkg::OP_BOX, '0, '0, '0, '0, '0, '0, '0, '0);
    push_query(sbo_pkg::OP_BOX, pack3(16'hFFF0, 16'hFFF0, 16'hFFF0), UNIT_X, UNIT_Y, UNIT_Z,
               pack3(16'd16, 16'd16, 16'd16), '0, pack3(16'hFFF0, 16'hFFF0, 16'd16), 16'd16);

    // random queries: raw bits, compact scenes, and near-boundary cases
    for (n = 0; n < RANDOM_QUERIES; n++) begin
      if (n % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n % 150 == 0) drain_next = 1'b1;
      kind = $urandom_range(0, 9);
      q.op = sbo_pkg::op_t'($urandom_range(0, 1));
      if (kind < 3) begin
        push_query(q.op, rand48(), rand48(), rand48(), rand48(), rand48(),
                   16'($urandom()), rand48(), 16'($urandom()));
      end else if (kind < 8) begin
        span = ($urandom_range(0, 1) == 1) ? 64 : 1024;
        for (c = 0; c < 3; c++) begin
          if (kind < 5) axes[c] = pack3(near(16384), near(16384), near(16384));
          else if ($urandom_range(0, 1) == 1) axes[c] = units[c];
          else axes[c] = neg3(units[c]);
        end
        push_query(q.op, pack3(near(span), near(span), near(span)), axes[0], axes[1],
                   axes[2], pack3(16'($urandom_range(0, span)), 16'($urandom_range(0, span)),
                   16'($urandom_range(0, span))), 16'($urandom_range(0, span)),
                   pack3(near(span), near(span), near(span)), 16'($urandom_range(0, span)));
      end else begin
        // place sphere B so that it just touches, just misses or just overlaps
        for (c = 0; c < 3; c++) begin
          ctr[c] = near(1024);
          hs[c]  = 16'($urandom_range(0, 1000));
        end
        c   = $urandom_range(0, 2);
        len = $urandom_range(0, 2000);
        ra  = 16'($urandom_range(0, len));
        lim = len - ra + $urandom_range(0, 2) - 1;
        rb  = (lim < 0) ? '0 : 16'(lim);
        axes[0] = pack3(ctr[0], ctr[1], ctr[2]);
        if (q.op == sbo_pkg::OP_BOX) begin
          ctr[c] = ctr[c] + hs[c] + rb + 16'($urandom_range(0, 2)) - 16'd1;
          push_query(sbo_pkg::OP_BOX, axes[0], UNIT_X, UNIT_Y, UNIT_Z,
                     pack3(hs[0], hs[1], hs[2]), ra, pack3(ctr[0], ctr[1], ctr[2]), rb);
        end else begin
          ctr[c] = ctr[c] + 16'(len);
          push_query(sbo_pkg::OP_SPHERE, axes[0], rand48(), rand48(), rand48(), rand48(), ra,
                     pack3(ctr[0], ctr[1], ctr[2]), rb);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to be taken and every result to arrive
    while (query_q.size() != 0 || start || hit_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
